// File: hdl/aes_pkg.sv
package aes_pkg;

   localparam int NumRounds  = 14;
   localparam int KeyEntries = 30;

   // register indexes of the csr port
   typedef enum logic [2:0] {
      REG_KEY0    = 3'd0,
      REG_KEY1    = 3'd1,
      REG_KEY2    = 3'd2,
      REG_KEY3    = 3'd3,
      REG_MODE    = 3'd4,
      REG_NONCE   = 3'd5,
      REG_COUNTER = 3'd6
   } reg_index_type;

   localparam logic MODE_ECB = 1'b0;
   localparam logic MODE_CTR = 1'b1;

   // request to the round unit from the sequencer
   typedef struct packed {
      logic         start;
      logic [127:0] block;
      logic [4:0]   count;
   } round_cmd_type;

   typedef struct packed {
      logic         done;
      logic [127:0] block;
      logic [4:0]   count;
   } round_rsp_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   function automatic logic [7:0] rcon(input logic [2:0] i);
      logic [7:0] r;
      case (i)
         3'd0: r = 8'h01;
         3'd1: r = 8'h02;
         3'd2: r = 8'h04;
         3'd3: r = 8'h08;
         3'd4: r = 8'h10;
         3'd5: r = 8'h20;
         3'd6: r = 8'h40;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // one round without the key: sub bytes, shift rows, optional mix columns
   function automatic logic [127:0] round_fn(input logic [127:0] s, input logic last);
      logic [7:0] sb [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [127:0] o;
      for (int i = 0; i < 16; i++) begin
         sb[i] = s[127-8*i -: 8];
      end
      for (int i = 0; i < 16; i++) begin
         t[i] = sbox(sb[((((i >> 2) + (i & 3)) & 3) << 2) + (i & 3)]);
      end
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) begin
         o[127-8*i -: 8] = t[i];
      end
      return o;
   endfunction

endpackage

// File: hdl/aes_req_if.sv
interface aes_req_if;
   logic        valid;
   logic        ready;
   logic        restart;
   logic [63:0] block_high;
   logic [63:0] block_low;
   logic [4:0]  byte_count;
   modport source (output valid, restart, block_high, block_low, byte_count, input ready);
   modport sink (input valid, restart, block_high, block_low, byte_count, output ready);
endinterface

// File: hdl/aes_rsp_if.sv
interface aes_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_high;
   logic [63:0] out_low;
   logic [4:0]  valid_bytes;
   modport source (output valid, out_high, out_low, valid_bytes, input ready);
   modport sink (input valid, out_high, out_low, valid_bytes, output ready);
endinterface

// File: hdl/aes256_ecb_ctr_engine_core.sv
// AES-256 encryption engine, ECB or CTR keystream, one result item per request item.
// For each item the single round unit applies one round key at a time, fetching each
// 128-bit round key as two 64-bit words from a round key memory with one read and one
// write port, over the initial key addition and fourteen rounds. The first item after
// reset or a key write also runs the key expansion first, one memory entry per cycle.
// The result sits in an output register, so the next item is taken while it waits.
module aes256_ecb_ctr_engine_core (
   input  logic        clock,
   input  logic        reset,
   aes_req_if.sink     req,
   aes_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import aes_pkg::*;

   logic [63:0] key_ff [4];
   logic        mode_ff;
   logic [63:0] nonce_ff, cstart_ff, ctr_ff, ctr_in;
   logic        busy_ff, busy_in;
   logic        stale_ff;
   logic        wr;
   logic [2:0]  widx;
   logic [4:0]  n;
   round_cmd_type cmd;
   round_rsp_type crsp;
   logic        ovalid_ff;
   logic [63:0] ohi_ff, olo_ff;
   logic [4:0]  ocnt_ff;
   logic [127:0] mask;
   logic        out_hold;

   assign csr_pready = 1'b1;
   assign wr   = csr_psel && csr_penable && csr_pwrite;
   assign widx = csr_paddr[5:3];

   // register read back
   always_comb begin
      case (widx)
         REG_KEY0:    csr_prdata = key_ff[0];
         REG_KEY1:    csr_prdata = key_ff[1];
         REG_KEY2:    csr_prdata = key_ff[2];
         REG_KEY3:    csr_prdata = key_ff[3];
         REG_MODE:    csr_prdata = {63'd0, mode_ff};
         REG_NONCE:   csr_prdata = nonce_ff;
         REG_COUNTER: csr_prdata = cstart_ff;
         default:     csr_prdata = 64'd0;
      endcase
   end

   assign req.ready = !busy_ff;
   assign n = (req.byte_count > 5'd16) ? 5'd16 : req.byte_count;

   // output register full and not being drained
   assign out_hold = ovalid_ff && !rsp.ready;

   // request into the round unit
   always_comb begin
      ctr_in = req.restart ? cstart_ff : ctr_ff;
      cmd.start = req.valid && req.ready;
      cmd.count = n;
      cmd.block = (mode_ff == MODE_CTR) ? {nonce_ff, ctr_in} : {req.block_high, req.block_low};
   end

   always_comb begin
      busy_in = busy_ff;
      if (cmd.start) busy_in = 1'b1;
      if (crsp.done && !out_hold) busy_in = 1'b0;
   end

   aes_core u_core (
      .clock(clock), .reset(reset),
      .key({key_ff[0], key_ff[1], key_ff[2], key_ff[3]}),
      .key_stale(stale_ff), .hold(out_hold), .cmd(cmd), .rsp(crsp)
   );

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         mask[127-8*i -: 8] = (5'(i) < crsp.count) ? 8'hff : 8'h00;
      end
   end

   // configuration registers and running counter
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= 64'd0;
         mode_ff   <= MODE_CTR;
         nonce_ff  <= 64'd0;
         cstart_ff <= 64'd0;
         ctr_ff    <= 64'd0;
         stale_ff  <= 1'b0;
         busy_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (cmd.start) stale_ff <= 1'b0;
         if (wr) begin
            case (widx)
               REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
                  key_ff[widx[1:0]] <= csr_pwdata;
                  stale_ff <= 1'b1;
               end
               REG_MODE:    mode_ff <= csr_pwdata[0];
               REG_NONCE:   nonce_ff <= csr_pwdata;
               REG_COUNTER: begin
                  cstart_ff <= csr_pwdata;
                  ctr_ff    <= csr_pwdata;
               end
               default: ;
            endcase
         end
         if (cmd.start) begin
            ctr_ff <= (mode_ff == MODE_CTR) ? ctr_in + 64'd1 : ctr_in;
         end
         if (crsp.done && busy_ff && !out_hold) begin
            ovalid_ff <= 1'b1;
         end else if (rsp.valid && rsp.ready) begin
            ovalid_ff <= 1'b0;
         end
      end
   end

   // output register; the round unit holds its result while this is full and not being drained
   always_ff @(posedge clock) begin
      if (crsp.done && !out_hold) begin
         ohi_ff  <= crsp.block[127:64] & mask[127:64];
         olo_ff  <= crsp.block[63:0] & mask[63:0];
         ocnt_ff <= crsp.count;
      end
   end

   assign rsp.valid       = ovalid_ff;
   assign rsp.out_high    = ohi_ff;
   assign rsp.out_low     = olo_ff;
   assign rsp.valid_bytes = ocnt_ff;

   a_busy_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> busy_ff)
      else $error("accepted item not marked busy");
   a_ctr_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.start && mode_ff == MODE_CTR && !req.restart && !wr) |=>
      ctr_ff == $past(ctr_ff) + 64'd1)
      else $error("counter did not advance");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.valid_bytes <= 5'd16)
      else $error("byte count above sixteen");
endmodule

// File: hdl/aes_core.sv
// key schedule and round unit around the round key memory
module aes_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [255:0]           key,
   input  logic                   key_stale,
   input  logic                   hold,
   input  aes_pkg::round_cmd_type cmd,
   output aes_pkg::round_rsp_type rsp
);
   import aes_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXP  = 4'b0010,
      ST_RUN  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   logic         expanded_ff, expanded_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic [127:0] st_ff, st_in;
   logic [4:0]   cnt_ff, cnt_in;
   // key schedule window of eight words
   logic [255:0] win_ff, win_in;
   logic [2:0]   kstep_ff, kstep_in;
   logic [4:0]   waddr_ff, waddr_in;
   logic         kphase_ff, kphase_in;

   // round key memory, two entries per round key
   logic [63:0]  rk_mem [KeyEntries];
   logic [4:0]   raddr;
   logic [63:0]  rdata_ff;
   logic         we;
   logic [63:0]  wdata;
   logic [63:0]  rk_hi_ff, rk_hi_in;
   logic [255:0] win_next;
   logic [31:0]  t0, t4;

   // next eight schedule words
   always_comb begin
      win_next = win_ff;
      t0 = sub_word({win_ff[23:0], win_ff[31:24]}) ^ {rcon(kstep_ff), 24'h0};
      win_next[255:224] = win_ff[255:224] ^ t0;
      for (int j = 1; j < 4; j++) begin
         win_next[255-32*j -: 32] = win_ff[255-32*j -: 32] ^ win_next[255-32*(j-1) -: 32];
      end
      t4 = sub_word(win_next[159:128]);
      win_next[127:96] = win_ff[127:96] ^ t4;
      for (int j = 5; j < 8; j++) begin
         win_next[255-32*j -: 32] = win_ff[255-32*j -: 32] ^ win_next[255-32*(j-1) -: 32];
      end
   end

   // write one 64-bit entry per cycle from the window
   always_comb begin
      case (waddr_ff[1:0])
         2'd0: wdata = win_ff[255:192];
         2'd1: wdata = win_ff[191:128];
         2'd2: wdata = win_ff[127:64];
         default: wdata = win_ff[63:0];
      endcase
   end
   assign we = (state_ff == ST_EXP);

   always_ff @(posedge clock) begin
      if (we) begin
         rk_mem[waddr_ff] <= wdata;
      end
      rdata_ff <= rk_mem[raddr];
   end

   // read address: two entries per round, high word first
   assign raddr = 5'({rnd_in, kphase_in});

   always_comb begin
      state_in    = state_ff;
      expanded_in = expanded_ff & ~key_stale;
      rnd_in      = rnd_ff;
      st_in       = st_ff;
      cnt_in      = cnt_ff;
      win_in      = win_ff;
      kstep_in    = kstep_ff;
      waddr_in    = waddr_ff;
      kphase_in   = 1'b0;
      rk_hi_in    = rk_hi_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               st_in  = cmd.block;
               cnt_in = cmd.count;
               rnd_in = 4'd0;
               if (!expanded_ff || key_stale) begin
                  state_in = ST_EXP;
                  win_in   = key;
                  kstep_in = 3'd0;
                  waddr_in = 5'd0;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_EXP: begin
            waddr_in = waddr_ff + 5'd1;
            if (waddr_ff[1:0] == 2'd3) begin
               win_in   = win_next;
               kstep_in = kstep_ff + 3'd1;
            end
            if (waddr_ff == 5'(KeyEntries - 1)) begin
               expanded_in = 1'b1;
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            // phase 0 reads high entry, phase 1 the low entry then applies
            kphase_in = ~kphase_ff;
            if (kphase_ff) begin
               if (rnd_ff == 4'd0) begin
                  st_in = st_ff ^ {rk_hi_ff, rdata_ff};
               end else begin
                  st_in = round_fn(st_ff, rnd_ff == 4'(NumRounds)) ^ {rk_hi_ff, rdata_ff};
               end
               kphase_in = 1'b0;
               if (rnd_ff == 4'(NumRounds)) begin
                  state_in = ST_DONE;
               end else begin
                  rnd_in = rnd_ff + 4'd1;
               end
            end else begin
               rk_hi_in = rdata_ff;
            end
         end
         ST_DONE: begin
            // keep the result until the output register can take it
            if (!hold) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // the memory read is registered, so phase 1 holds rk high
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         expanded_ff <= 1'b0;
         kphase_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         expanded_ff <= expanded_in;
         kphase_ff   <= kphase_in;
      end
      rnd_ff   <= rnd_in;
      st_ff    <= st_in;
      cnt_ff   <= cnt_in;
      win_ff   <= win_in;
      kstep_ff <= kstep_in;
      waddr_ff <= waddr_in;
      rk_hi_ff <= rk_hi_in;
   end

   assign rsp.done  = (state_ff == ST_DONE);
   assign rsp.block = st_ff;
   assign rsp.count = cnt_ff;

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      rsp.done |-> $past(state_ff == ST_RUN || state_ff == ST_DONE))
      else $error("done without a run");
   a_exp_sets: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> expanded_ff || key_stale)
      else $error("run with unexpanded key");
   a_phase_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RUN) |=> !kphase_ff)
      else $error("phase left set");
endmodule
